// ----- design/rau_pkg.sv -----
// Shared constants for the rational arithmetic unit.
`default_nettype none
package rau_pkg;
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int CMD_WIDTH = 3;
  localparam int WIDE_OUT_WIDTH = 33;
  localparam int NARROW_OUT_WIDTH = 31;
  localparam logic [CMD_WIDTH-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_DIV = 3'd3;
endpackage
`default_nettype wire

// ----- design/rau_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module rau_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient,
  output logic      [WIDTH-1:0] remainder
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dsr;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {remainder, quotient[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        remainder <= diff[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- design/rational_arithmetic_unit.sv -----
// Top level: fraction arithmetic with reduction to lowest terms.
//
// Input channel (in_valid/in_stall) carries cmd and two fractions a_num/a_den
// and b_num/b_den. Output channel (out_valid/out_stall) carries one result per
// transaction: the unreduced fraction, then the whole part, remainder
// numerator and reduced denominator, with whole and error flags.
// One transaction is handled at a time; in_stall is high from acceptance
// until the result has been taken. A shared multiplier forms the cross
// products in states S_MUL0, S_MUL1 and S_MUL2; a serial divider of
// 2*OPERAND_WIDTH bits then runs Euclid's algorithm (one division per step)
// and three more divisions (numerator and denominator by the divisor, then
// whole part and remainder). Euclid's step count depends on the data. A zero
// denominator goes from S_CHECK straight to S_DONE with div_error set.
// The result stays on the output ports while out_stall is high.
// Synchronous reset returns the sequencer to idle and drops out_valid.
`default_nettype none
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic        [CMD_WIDTH-1:0]         cmd,
  input  wire logic signed [OPERAND_WIDTH-1:0]     a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0]     a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0]     b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0]     b_den,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [WIDE_OUT_WIDTH-1:0]         raw_num,
  output logic        [NARROW_OUT_WIDTH-1:0]       raw_den,
  output logic signed [WIDE_OUT_WIDTH-1:0]         whole_part,
  output logic signed [NARROW_OUT_WIDTH-1:0]       rem_num,
  output logic        [NARROW_OUT_WIDTH-1:0]       red_den,
  output logic                                     is_whole,
  output logic                                     div_error
);
  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;
  localparam int M  = 2 * W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL0  = 10'b0000000010,
    S_MUL1  = 10'b0000000100,
    S_MUL2  = 10'b0000001000,
    S_SUM   = 10'b0000010000,
    S_CHECK = 10'b0000100000,
    S_GCD   = 10'b0001000000,
    S_REDN  = 10'b0010000000,
    S_REDD  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic [CMD_WIDTH-1:0]     op;
  logic signed [W-1:0]      an, ad, bn, bd;
  logic signed [PW-1:0]     p0, p1, den;
  logic signed [NW-1:0]     num;
  logic [M-1:0]             mag, dmag, gx, gy;
  logic                     running;
  logic                     split;
  logic signed [W-1:0]      ma, mb;
  logic signed [PW-1:0]     prod;
  logic signed [NW-1:0]     nneg, p0x, p1x;
  logic signed [PW-1:0]     dneg;
  logic                     is_add, is_sub, is_mul, is_div, is_red;
  logic                     div_start, div_done;
  logic [M-1:0]             div_a, div_b, div_q, div_r;
  logic [63:0]              num64, den64, q64, r64, d64;

  assign is_add = (op == CMD_ADD);
  assign is_sub = (op == CMD_SUB);
  assign is_mul = (op == CMD_MUL);
  assign is_div = (op == CMD_DIV);
  assign is_red = !(is_add || is_sub || is_mul || is_div);

  always_comb begin
    ma = an;
    mb = bd;
    unique case (state)
      S_MUL0: begin
        ma = an;
        mb = is_mul ? bn : (is_red ? W'(1) : bd);
      end
      S_MUL1: begin
        ma = bn;
        mb = ad;
      end
      S_MUL2: begin
        ma = ad;
        mb = is_div ? bn : (is_red ? W'(1) : bd);
      end
      default: begin
        ma = an;
        mb = bd;
      end
    endcase
  end

  assign prod = ma * mb;
  assign p0x  = $signed({p0[PW-1], p0});
  assign p1x  = $signed({p1[PW-1], p1});
  assign nneg = den[PW-1] ? -num : num;
  assign dneg = den[PW-1] ? -den : den;

  always_comb begin
    div_start = 1'b0;
    div_a     = gx;
    div_b     = gy;
    unique case (state)
      S_GCD: begin
        if (!running) begin
          div_start = 1'b1;
          if (gy == '0) begin
            div_a = mag;
            div_b = gx;
          end
        end
      end
      S_REDN: begin
        div_start = div_done;
        div_a     = dmag;
        div_b     = gx;
      end
      S_REDD: begin
        div_start = div_done && !split;
        div_a     = mag;
        div_b     = div_q;
      end
      default: div_start = 1'b0;
    endcase
  end

  rau_div #(.WIDTH(M)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  assign num64 = 64'(num);
  assign den64 = 64'(den);
  assign d64   = 64'(dmag);
  assign q64   = num[NW-1] ? -(64'(div_q)) : 64'(div_q);
  assign r64   = num[NW-1] ? -(64'(div_r)) : 64'(div_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      running <= 1'b0;
      split   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_MUL0;
        S_MUL0:  state <= S_MUL1;
        S_MUL1:  state <= S_MUL2;
        S_MUL2:  state <= S_SUM;
        S_SUM:   state <= S_CHECK;
        S_CHECK: state <= (den == '0) ? S_DONE : S_GCD;
        S_GCD: begin
          if (!running) begin
            if (gy == '0) state <= S_REDN;
            else running <= 1'b1;
          end else if (div_done) begin
            running <= 1'b0;
          end
        end
        S_REDN: begin
          if (div_done) begin
            state <= S_REDD;
            split <= 1'b0;
          end
        end
        S_REDD: begin
          if (div_done) begin
            if (split) state <= S_DONE;
            else split <= 1'b1;
          end
        end
        S_DONE:  if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op <= cmd;
        an <= a_num;
        ad <= a_den;
        bn <= b_num;
        bd <= b_den;
      end
      S_MUL0: p0 <= prod;
      S_MUL1: p1 <= prod;
      S_MUL2: den <= prod;
      S_SUM: begin
        if (is_add) num <= p0x + p1x;
        else if (is_sub) num <= p0x - p1x;
        else num <= p0x;
      end
      S_CHECK: begin
        if (den == '0) begin
          raw_num    <= num64[WIDE_OUT_WIDTH-1:0];
          raw_den    <= '0;
          whole_part <= '0;
          rem_num    <= '0;
          red_den    <= '0;
          is_whole   <= 1'b0;
          div_error  <= 1'b1;
        end else begin
          num  <= nneg;
          den  <= dneg;
          mag  <= nneg[NW-1] ? M'(-nneg) : M'(nneg);
          dmag <= M'(dneg);
          gx   <= nneg[NW-1] ? M'(-nneg) : M'(nneg);
          gy   <= M'(dneg);
        end
      end
      S_GCD: begin
        if (running && div_done) begin
          gx <= gy;
          gy <= div_r;
        end
      end
      S_REDN: if (div_done) mag <= div_q;
      S_REDD: begin
        if (div_done) begin
          if (!split) begin
            dmag <= div_q;
          end else begin
            raw_num    <= num64[WIDE_OUT_WIDTH-1:0];
            raw_den    <= den64[NARROW_OUT_WIDTH-1:0];
            whole_part <= q64[WIDE_OUT_WIDTH-1:0];
            rem_num    <= r64[NARROW_OUT_WIDTH-1:0];
            red_den    <= d64[NARROW_OUT_WIDTH-1:0];
            is_whole   <= (div_r == '0);
            div_error  <= 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

// ----- test/rational_arithmetic_unit_tb.sv -----
// Testbench for the rational arithmetic unit: directed table plus random fractions.
`default_nettype none
module rational_arithmetic_unit_tb;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam logic [CMD_WIDTH-1:0] CMD_REDUCE = 3'd4;
  localparam int N_RANDOM = 640;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [CMD_WIDTH-1:0] op;
    logic signed [W-1:0] an, ad, bn, bd;
  } fraction_op_t;

  typedef struct packed {
    logic [WIDE_OUT_WIDTH-1:0] raw_num;
    logic [NARROW_OUT_WIDTH-1:0] raw_den;
    logic [WIDE_OUT_WIDTH-1:0] whole_part;
    logic [NARROW_OUT_WIDTH-1:0] rem_num;
    logic [NARROW_OUT_WIDTH-1:0] red_den;
    logic is_whole;
    logic div_error;
  } fraction_result_t;

  typedef struct {
    fraction_op_t op;
    bit has_fixed;
    fraction_result_t fixed;
  } stim_row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [CMD_WIDTH-1:0] cmd = '0;
  logic signed [W-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic in_stall, out_valid, is_whole, div_error;
  logic signed [WIDE_OUT_WIDTH-1:0] raw_num, whole_part;
  logic [NARROW_OUT_WIDTH-1:0] raw_den, red_den;
  logic signed [NARROW_OUT_WIDTH-1:0] rem_num;

  fraction_result_t pending_results[$];
  stim_row_t directed[$];
  int fail_count = 0;
  longint cycle_count = 0;
  bit stim_done = 0;

  rational_arithmetic_unit uut (.*);

  always #10 clk = ~clk;

  function automatic fraction_result_t reduce_fraction(fraction_op_t t);
    fraction_result_t r;
    longint an, ad, bn, bd, num, den;
    longint unsigned mag, dmag, x, y, tmp, q, rm;
    bit neg;
    an = t.an; ad = t.ad; bn = t.bn; bd = t.bd;
    case (t.op)
      CMD_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      CMD_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      CMD_MUL: begin num = an * bn; den = ad * bd; end
      CMD_DIV: begin num = an * bd; den = ad * bn; end
      default: begin num = an; den = ad; end
    endcase
    r = '0;
    if (den == 0) begin
      r.raw_num = num[WIDE_OUT_WIDTH-1:0];
      r.div_error = 1'b1;
      return r;
    end
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    neg = num < 0;
    mag = neg ? -num : num;
    dmag = den;
    x = mag; y = dmag;
    while (y != 0) begin
      tmp = x % y;
      x = y;
      y = tmp;
    end
    mag = mag / x;
    dmag = dmag / x;
    q = mag / dmag;
    rm = mag % dmag;
    if (neg) begin
      q = -q;
      rm = -rm;
    end
    r.raw_num = num[WIDE_OUT_WIDTH-1:0];
    r.raw_den = den[NARROW_OUT_WIDTH-1:0];
    r.whole_part = q[WIDE_OUT_WIDTH-1:0];
    r.rem_num = rm[NARROW_OUT_WIDTH-1:0];
    r.red_den = dmag[NARROW_OUT_WIDTH-1:0];
    r.is_whole = (rm == 0);
    return r;
  endfunction

  function automatic fraction_op_t pick_fraction_op();
    fraction_op_t t;
    int k;
    k = $urandom_range(0, 9);
    t.op = $urandom_range(0, 9) == 0 ? CMD_WIDTH'($urandom_range(5, 7))
                                     : CMD_WIDTH'($urandom_range(0, 4));
    t.an = W'($urandom); t.ad = W'($urandom); t.bn = W'($urandom); t.bd = W'($urandom);
    if (k < 4) begin
      t.an = $signed(16'($urandom_range(0, 60))) - 16'sd30;
      t.ad = $signed(16'($urandom_range(0, 60))) - 16'sd30;
      t.bn = $signed(16'($urandom_range(0, 60))) - 16'sd30;
      t.bd = $signed(16'($urandom_range(0, 60))) - 16'sd30;
    end else if (k == 4) begin
      t.ad = 0;
    end else if (k == 5) begin
      t.bn = t.an;
      t.bd = t.ad;
    end
    return t;
  endfunction

  function automatic stim_row_t mk(logic [CMD_WIDTH-1:0] op, int an, int ad, int bn, int bd);
    stim_row_t s;
    s.op = '{op, W'(an), W'(ad), W'(bn), W'(bd)};
    s.has_fixed = 0;
    s.fixed = '0;
    return s;
  endfunction

  function automatic stim_row_t mkf(logic [CMD_WIDTH-1:0] op, int an, int ad, int bn, int bd,
                                     fraction_result_t f);
    stim_row_t s;
    s = mk(op, an, ad, bn, bd);
    s.has_fixed = 1;
    s.fixed = f;
    return s;
  endfunction

  task automatic send_fraction_op(fraction_op_t t);
    int gap;
    gap = $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= t.op; a_num <= t.an; a_den <= t.ad; b_num <= t.bn; b_den <= t.bd;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    stim_row_t row;
    fraction_op_t t;
    directed.push_back(mkf(CMD_REDUCE, 6, 0, 0, 0,
      '{33'd6, 31'd0, 33'd0, 31'd0, 31'd0, 1'b0, 1'b1}));
    directed.push_back(mkf(CMD_REDUCE, 0, 5, 0, 0,
      '{33'd0, 31'd5, 33'd0, 31'd0, 31'd1, 1'b1, 1'b0}));
    directed.push_back(mkf(CMD_REDUCE, 6, 3, 0, 0,
      '{33'd6, 31'd3, 33'd2, 31'd0, 31'd1, 1'b1, 1'b0}));
    directed.push_back(mkf(CMD_REDUCE, 7, -2, 0, 0,
      '{-33'sd7, 31'd2, -33'sd3, -31'sd1, 31'd2, 1'b0, 1'b0}));
    directed.push_back(mkf(CMD_DIV, 1, 2, 0, 3,
      '{33'd3, 31'd0, 33'd0, 31'd0, 31'd0, 1'b0, 1'b1}));
    directed.push_back(mk(CMD_ADD, 1, 2, 1, 3));
    directed.push_back(mk(CMD_SUB, 1, 2, 1, 3));
    directed.push_back(mk(CMD_MUL, -3, 4, 2, 9));
    directed.push_back(mk(CMD_DIV, 3, -4, -2, 5));
    directed.push_back(mk(CMD_ADD, -32768, -32768, -32768, -32768));
    directed.push_back(mk(CMD_SUB, 32767, -32768, -32768, 32767));
    directed.push_back(mk(CMD_MUL, -32768, 1, -32768, 1));
    directed.push_back(mk(CMD_MUL, 32767, -32768, 32767, -1));
    directed.push_back(mk(CMD_DIV, -32768, 32767, 1, -32768));
    directed.push_back(mk(CMD_REDUCE, -32768, -1, 0, 0));
    directed.push_back(mk(CMD_REDUCE, 32767, 32767, 0, 0));
    directed.push_back(mk(3'd5, 10, 4, 1, 1));
    directed.push_back(mk(3'd6, -9, 6, 0, 0));
    directed.push_back(mk(3'd7, 17, -5, -1, -1));
    directed.push_back(mk(CMD_SUB, 3, 7, 3, 7));
    directed.push_back(mk(CMD_ADD, 65535, 65535, 21845, 43690));
    directed.push_back(mk(CMD_DIV, 0, 5, 0, 7));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      row = directed[i];
      pending_results.push_back(row.has_fixed ? row.fixed : reduce_fraction(row.op));
      send_fraction_op(row.op);
    end
    repeat (N_RANDOM) begin
      t = pick_fraction_op();
      pending_results.push_back(reduce_fraction(t));
      send_fraction_op(t);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= $urandom_range(0, 9) == 0 ? 1'b1 : ~out_stall;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    fraction_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction raw_num=%0d", raw_num);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (raw_num !== e.raw_num) begin
          $error("raw_num expected %0d actual %0d", $signed(e.raw_num), raw_num);
          fail_count++;
        end
        if (raw_den !== e.raw_den) begin
          $error("raw_den expected %0d actual %0d", e.raw_den, raw_den);
          fail_count++;
        end
        if (whole_part !== e.whole_part) begin
          $error("whole_part expected %0d actual %0d", $signed(e.whole_part), whole_part);
          fail_count++;
        end
        if (rem_num !== e.rem_num) begin
          $error("rem_num expected %0d actual %0d", $signed(e.rem_num), rem_num);
          fail_count++;
        end
        if (red_den !== e.red_den) begin
          $error("red_den expected %0d actual %0d", e.red_den, red_den);
          fail_count++;
        end
        if (is_whole !== e.is_whole) begin
          $error("is_whole expected %0d actual %0d", e.is_whole, is_whole);
          fail_count++;
        end
        if (div_error !== e.div_error) begin
          $error("div_error expected %0d actual %0d", e.div_error, div_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
`default_nettype wire

// ----- rational_arithmetic_unit.f -----
design/rau_pkg.sv
design/rau_div.sv
design/rational_arithmetic_unit.sv
test/rational_arithmetic_unit_tb.sv
